[rtl/spo_pkg.sv]
// ----------------------------------------------------------------------------
// spo_pkg: shared types and constants of the symmetric peer order block
// Field widths, register codes, reset values, and the structs passed
// between the sequencer, the divider and the register file.
// ----------------------------------------------------------------------------
package spo_pkg;

    // Field widths
    localparam int RANK_W = 8;
    localparam int DIV_W  = 9;
    localparam int POS_W  = 6;
    localparam int CFG_AW = 4;
    localparam int CFG_DW = 32;

    // Parameter defaults
    localparam int MAX_ENTRIES_DEF = 64;
    localparam int MAX_RANKS_DEF   = 256;

    // Register indexes (paddr[3:2])
    localparam logic [1:0] REG_MY_RANK    = 2'd0;
    localparam logic [1:0] REG_RANK_SIZE  = 2'd1;
    localparam logic [1:0] REG_GROUP_SIZE = 2'd2;

    // Register reset values
    localparam logic [RANK_W-1:0] MY_RANK_RST    = 8'd0;
    localparam logic [DIV_W-1:0]  RANK_SIZE_RST  = 9'd8;
    localparam logic [DIV_W-1:0]  GROUP_SIZE_RST = 9'd1;

    typedef struct packed {
        logic [RANK_W-1:0] my_rank;
        logic [DIV_W-1:0]  rank_size;
        logic [DIV_W-1:0]  group_size;
    } t_cfg;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
        logic [DIV_W-1:0] remainder;
    } t_div_rsp;

endpackage

[rtl/spo_div.sv]
// ----------------------------------------------------------------------------
// spo_div: shared restoring divider
// One quotient bit per cycle; done is high for a single cycle, registered together with the last bit.
// ----------------------------------------------------------------------------
module spo_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  spo_pkg::t_div_req i_req,
    output spo_pkg::t_div_rsp o_rsp
);

    localparam int DW    = spo_pkg::DIV_W;
    localparam int CNT_W = $clog2(DW + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DW-1:0]    r_quo;
    logic [DW-1:0]    r_rem;
    logic [DW-1:0]    r_dsr;
    logic [DW:0]      shifted;
    logic [DW:0]      diff;
    logic             ge;

    // Trial subtract of the shifted partial remainder
    always_comb begin
        shifted = {r_rem, r_quo[DW-1]};
        diff    = shifted - {1'b0, r_dsr};
        ge      = (shifted >= {1'b0, r_dsr});
    end

    // Sequence the iterations
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Advance quotient and remainder
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.dividend;
            r_rem <= '0;
            r_dsr <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= ge ? diff[DW-1:0] : shifted[DW-1:0];
            r_quo <= {r_quo[DW-2:0], ge};
        end
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.quotient  = r_quo;
    assign o_rsp.remainder = r_rem;

endmodule

[rtl/spo_cfg.sv]
// ----------------------------------------------------------------------------
// spo_cfg: configuration registers
// Holds my_rank, rank_size and group_size behind the APB-style port.
// ----------------------------------------------------------------------------
module spo_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [spo_pkg::CFG_AW-1:0]  paddr,
    input  logic [spo_pkg::CFG_DW-1:0]  pwdata,
    output logic [spo_pkg::CFG_DW-1:0]  prdata,
    output spo_pkg::t_cfg               o_cfg
);

    localparam int RW = spo_pkg::RANK_W;
    localparam int DW = spo_pkg::DIV_W;

    spo_pkg::t_cfg r_cfg;
    logic          wr_en;

    assign wr_en = psel && penable && pwrite;

    // Write the addressed register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.my_rank    <= spo_pkg::MY_RANK_RST;
            r_cfg.rank_size  <= spo_pkg::RANK_SIZE_RST;
            r_cfg.group_size <= spo_pkg::GROUP_SIZE_RST;
        end else if (wr_en) begin
            unique case (paddr[3:2])
                spo_pkg::REG_MY_RANK:    r_cfg.my_rank    <= pwdata[RW-1:0];
                spo_pkg::REG_RANK_SIZE:  r_cfg.rank_size  <= pwdata[DW-1:0];
                spo_pkg::REG_GROUP_SIZE: r_cfg.group_size <= pwdata[DW-1:0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb begin
        unique case (paddr[3:2])
            spo_pkg::REG_MY_RANK:    prdata = spo_pkg::CFG_DW'(r_cfg.my_rank);
            spo_pkg::REG_RANK_SIZE:  prdata = spo_pkg::CFG_DW'(r_cfg.rank_size);
            spo_pkg::REG_GROUP_SIZE: prdata = spo_pkg::CFG_DW'(r_cfg.group_size);
            default:                 prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

[rtl/symmetric_peer_order.sv]
// Items load one per cycle; the closing item leads to a check state, then three divisions
// (one if rank_size fails to divide, none if reordering is off), then the board walk over
// each board distance and candidate rank, then S_DECIDE, then per result S_EMIT_A, S_EMIT_B
// and S_EMIT_W, the last waiting out output stall. One list at a time: input is held off
// from the closing item to the last result. Reset (synchronous, active low) empties the
// list, clears the rank present bits and loads my_rank = 0, rank_size = 8, group_size = 1.
// ----------------------------------------------------------------------------
// symmetric_peer_order: symmetric board-order reordering of a peer list
// Loads a list of peer ranks, then emits their positions either in original
// order or walking boards right-ascending and left-descending by distance.
// ----------------------------------------------------------------------------
module symmetric_peer_order #(
    parameter int MAX_ENTRIES = spo_pkg::MAX_ENTRIES_DEF,
    parameter int MAX_RANKS   = spo_pkg::MAX_RANKS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // input items
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [spo_pkg::RANK_W-1:0]  i_peer_rank,
    input  logic                        i_list_end,
    // result items
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [spo_pkg::POS_W-1:0]   o_orig_position,
    output logic [spo_pkg::RANK_W-1:0]  o_out_rank,
    output logic                        o_reordered,
    output logic                        o_run_end,
    // configuration
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [spo_pkg::CFG_AW-1:0]  paddr,
    input  logic [spo_pkg::CFG_DW-1:0]  pwdata,
    output logic [spo_pkg::CFG_DW-1:0]  prdata,
    output logic                        pready
);

    localparam int RW        = spo_pkg::RANK_W;
    localparam int DW        = spo_pkg::DIV_W;
    localparam int ENTRY_AW  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W     = $clog2(MAX_ENTRIES + 1);
    localparam int MAP_DEPTH = (MAX_RANKS < (1 << RW)) ? MAX_RANKS : (1 << RW);
    localparam int MAP_AW    = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;

    localparam logic [DW-1:0]    MAP_LIM = DW'(MAP_DEPTH);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ENTRIES);
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

    typedef enum logic [11:0] {
        S_LOAD   = 12'b0000_0000_0001,
        S_CHECK  = 12'b0000_0000_0010,
        S_DIV1   = 12'b0000_0000_0100,
        S_DIV2   = 12'b0000_0000_1000,
        S_DIV3   = 12'b0000_0001_0000,
        S_STEP   = 12'b0000_0010_0000,
        S_RIGHT  = 12'b0000_0100_0000,
        S_LEFT   = 12'b0000_1000_0000,
        S_DECIDE = 12'b0001_0000_0000,
        S_EMIT_A = 12'b0010_0000_0000,
        S_EMIT_B = 12'b0100_0000_0000,
        S_EMIT_W = 12'b1000_0000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    spo_pkg::t_cfg     cfg;
    spo_pkg::t_div_req r_div_req;
    spo_pkg::t_div_rsp div_rsp;

    // Memories
    logic [RW-1:0]       mem_entry [MAX_ENTRIES];
    logic [ENTRY_AW-1:0] mem_map   [MAP_DEPTH];
    logic [ENTRY_AW-1:0] mem_ob    [MAX_ENTRIES];

    // Control and working registers
    logic [CNT_W-1:0]     r_count;
    logic [RW-1:0]        r_last_rank;
    logic [CNT_W-1:0]     r_remotes;
    logic                 r_reord;
    logic [DW-1:0]        r_boards;
    logic [DW-1:0]        r_tmp;
    logic [DW-1:0]        r_right;
    logic [DW-1:0]        r_left;
    logic [DW-1:0]        r_k;
    logic [DW-1:0]        r_g;
    logic [CNT_W-1:0]     r_walk_len;
    logic                 r_rd_vld;
    logic                 r_present_q;
    logic [ENTRY_AW-1:0]  r_map_q;
    logic [MAP_DEPTH-1:0] r_present;
    logic [CNT_W-1:0]     r_idx;
    logic [ENTRY_AW-1:0]  r_ob_q;
    logic [ENTRY_AW-1:0]  r_pos;
    logic [RW-1:0]        r_store_q;
    logic                 r_out_valid;
    logic                 r_out_end;

    // Combinational helpers
    logic                 accept_in;
    logic                 store_ok;
    logic                 map_ok;
    logic                 own_last;
    logic [CNT_W-1:0]     remotes_c;
    logic                 skip;
    logic [DW-1:0]        cand;
    logic                 walk_rd;
    logic                 take;
    logic [DW:0]          right_sum;
    logic [DW-1:0]        right_nx;
    logic [DW-1:0]        left_nx;
    logic [DW-1:0]        half;
    logic [DW-1:0]        gs_m1;
    logic [CNT_W-1:0]     cnt_m1;
    logic [CNT_W-1:0]     idx_p1;
    logic                 emit_last;
    logic [ENTRY_AW-1:0]  pos_c;

    spo_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .o_cfg   (cfg)
    );

    spo_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_div_req),
        .o_rsp   (div_rsp)
    );

    assign pready     = 1'b1;
    assign o_in_ready = (r_state == S_LOAD);
    assign accept_in  = i_in_valid && o_in_ready;

    // Decode list state, board stepping and emit position
    always_comb begin
        store_ok  = (r_count < CNT_MAX);
        map_ok    = ({1'b0, i_peer_rank} < MAP_LIM);
        own_last  = (r_count != '0) && (r_last_rank == cfg.my_rank);
        remotes_c = own_last ? (r_count - CNT_ONE) : r_count;
        skip      = (r_count <= CNT_ONE) || (remotes_c <= CNT_ONE) ||
                    (cfg.rank_size == '0) || (cfg.group_size == '0);
        cand      = (r_state == S_LEFT) ? (r_left + r_k) : (r_right + r_k);
        walk_rd   = ((r_state == S_RIGHT) || (r_state == S_LEFT)) && (cand < MAP_LIM);
        take      = r_rd_vld && r_present_q && (r_walk_len < CNT_MAX);
        right_sum = {1'b0, r_right} + {1'b0, cfg.group_size};
        right_nx  = (right_sum >= {1'b0, cfg.rank_size}) ? '0 : right_sum[DW-1:0];
        left_nx   = (r_left == '0) ? (cfg.rank_size - cfg.group_size)
                                   : (r_left - cfg.group_size);
        half      = r_boards >> 1;
        gs_m1     = cfg.group_size - DW'(1);
        cnt_m1    = r_count - CNT_ONE;
        idx_p1    = r_idx + CNT_ONE;
        emit_last = (idx_p1 == r_count);
        if (!r_reord) begin
            pos_c = r_idx[ENTRY_AW-1:0];
        end else if (r_idx < r_remotes) begin
            pos_c = r_ob_q;
        end else begin
            pos_c = cnt_m1[ENTRY_AW-1:0];
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_LOAD: begin
                if (accept_in && i_list_end) n_state = S_CHECK;
            end
            S_CHECK: begin
                n_state = skip ? S_EMIT_A : S_DIV1;
            end
            S_DIV1: begin
                if (div_rsp.done) begin
                    n_state = (div_rsp.remainder != '0) ? S_EMIT_A : S_DIV2;
                end
            end
            S_DIV2: begin
                if (div_rsp.done) n_state = S_DIV3;
            end
            S_DIV3: begin
                if (div_rsp.done) n_state = S_STEP;
            end
            S_STEP: begin
                n_state = (r_g == half) ? S_DECIDE : S_RIGHT;
            end
            S_RIGHT: begin
                if (r_k == gs_m1) n_state = (r_left != r_right) ? S_LEFT : S_STEP;
            end
            S_LEFT: begin
                if (r_k == '0) n_state = S_STEP;
            end
            S_DECIDE: n_state = S_EMIT_A;
            S_EMIT_A: n_state = S_EMIT_B;
            S_EMIT_B: n_state = S_EMIT_W;
            S_EMIT_W: begin
                if (i_out_ready) n_state = emit_last ? S_LOAD : S_EMIT_A;
            end
            default: n_state = S_LOAD;
        endcase
    end

    // Sequencer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_count     <= '0;
            r_present   <= '0;
            r_rd_vld    <= 1'b0;
            r_walk_len  <= '0;
            r_div_req   <= '0;
            r_out_valid <= 1'b0;
            r_reord     <= 1'b0;
            r_idx       <= '0;
        end else begin
            r_state         <= n_state;
            r_div_req.start <= 1'b0;
            r_rd_vld        <= walk_rd;
            if (take) r_walk_len <= r_walk_len + CNT_ONE;
            unique case (r_state)
                S_LOAD: begin
                    if (accept_in && store_ok) begin
                        r_count     <= r_count + CNT_ONE;
                        r_last_rank <= i_peer_rank;
                        if (map_ok) r_present[i_peer_rank[MAP_AW-1:0]] <= 1'b1;
                    end
                end
                S_CHECK: begin
                    r_remotes <= remotes_c;
                    r_reord   <= 1'b0;
                    r_idx     <= '0;
                    if (!skip) begin
                        r_div_req <= '{start: 1'b1, dividend: cfg.rank_size,
                                       divisor: cfg.group_size};
                    end
                end
                S_DIV1: begin
                    if (div_rsp.done && (div_rsp.remainder == '0)) begin
                        r_boards  <= div_rsp.quotient;
                        r_div_req <= '{start: 1'b1, dividend: DW'(cfg.my_rank),
                                       divisor: cfg.rank_size};
                    end
                end
                S_DIV2: begin
                    if (div_rsp.done) begin
                        r_tmp     <= div_rsp.remainder;
                        r_div_req <= '{start: 1'b1, dividend: DW'(cfg.my_rank),
                                       divisor: cfg.group_size};
                    end
                end
                S_DIV3: begin
                    // own board base = (my_rank mod rank_size) - (my_rank mod group_size)
                    if (div_rsp.done) begin
                        r_right    <= r_tmp - div_rsp.remainder;
                        r_left     <= r_tmp - div_rsp.remainder;
                        r_g        <= '0;
                        r_walk_len <= '0;
                    end
                end
                S_STEP: begin
                    if (r_g != half) begin
                        r_g     <= r_g + DW'(1);
                        r_right <= right_nx;
                        r_left  <= left_nx;
                        r_k     <= '0;
                    end
                end
                S_RIGHT: begin
                    if (r_k != gs_m1) r_k <= r_k + DW'(1);
                end
                S_LEFT: begin
                    if (r_k != '0) r_k <= r_k - DW'(1);
                end
                S_DECIDE: begin
                    r_reord <= (r_walk_len == r_remotes);
                end
                S_EMIT_A: ;
                S_EMIT_B: begin
                    r_out_valid <= 1'b1;
                end
                S_EMIT_W: begin
                    if (i_out_ready) begin
                        r_out_valid <= 1'b0;
                        if (emit_last) begin
                            r_count   <= '0;
                            r_present <= '0;
                        end else begin
                            r_idx <= idx_p1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // Hold the present bit of the candidate for the write-back cycle
    always_ff @(posedge i_clk) begin
        if (walk_rd) r_present_q <= r_present[cand[MAP_AW-1:0]];
    end

    // Entry store: write on load, read at the emit position
    always_ff @(posedge i_clk) begin
        if (accept_in && store_ok) mem_entry[r_count[ENTRY_AW-1:0]] <= i_peer_rank;
        if (r_state == S_EMIT_B) begin
            r_store_q <= mem_entry[pos_c];
            r_pos     <= pos_c;
            r_out_end <= emit_last;
        end
    end

    // Rank-to-position map: later duplicates overwrite earlier ones
    always_ff @(posedge i_clk) begin
        if (accept_in && store_ok && map_ok) begin
            mem_map[i_peer_rank[MAP_AW-1:0]] <= r_count[ENTRY_AW-1:0];
        end
        if (walk_rd) r_map_q <= mem_map[cand[MAP_AW-1:0]];
    end

    // Order buffer: append found positions, read back in emit order
    always_ff @(posedge i_clk) begin
        if (take) mem_ob[r_walk_len[ENTRY_AW-1:0]] <= r_map_q;
        if (r_state == S_EMIT_A) r_ob_q <= mem_ob[r_idx[ENTRY_AW-1:0]];
    end

    assign o_out_valid     = r_out_valid;
    assign o_orig_position = spo_pkg::POS_W'(r_pos);
    assign o_out_rank      = r_store_q;
    assign o_reordered     = r_reord;
    assign o_run_end       = r_out_end;

endmodule

[dv/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for symmetric_peer_order
// Loads peer lists through the input channel, predicts the emitted positions
// in original or symmetric board order, and checks every result item against
// the oldest prediction. Registers are reprogrammed between phases only.
// ----------------------------------------------------------------------------
module testbench;

    localparam int ENTRY_CAP     = spo_pkg::MAX_ENTRIES_DEF;
    localparam int RANK_CAP      = spo_pkg::MAX_RANKS_DEF;
    localparam int SETTLE_CYCLES = 320;
    localparam int RANDOM_ITEMS  = 400;

    typedef struct {
        logic [spo_pkg::POS_W-1:0]  pos;
        logic [spo_pkg::RANK_W-1:0] rank;
        logic                       reordered;
        logic                       run_end;
    } t_peer_result;

    // Clock, reset and block inputs
    logic                        i_clk           = 1'b0;
    logic                        i_rst_n         = 1'b0;
    logic                        i_in_valid      = 1'b0;
    logic [spo_pkg::RANK_W-1:0]  i_peer_rank     = '0;
    logic                        i_list_end      = 1'b0;
    logic                        i_out_ready     = 1'b0;
    logic                        psel            = 1'b0;
    logic                        penable         = 1'b0;
    logic                        pwrite          = 1'b0;
    logic [spo_pkg::CFG_AW-1:0]  paddr           = '0;
    logic [spo_pkg::CFG_DW-1:0]  pwdata          = '0;

    // Block outputs
    logic                        o_in_ready;
    logic                        o_out_valid;
    logic [spo_pkg::POS_W-1:0]   o_orig_position;
    logic [spo_pkg::RANK_W-1:0]  o_out_rank;
    logic                        o_reordered;
    logic                        o_run_end;
    logic [spo_pkg::CFG_DW-1:0]  prdata;
    logic                        pready;

    // Predictor state and register copies
    logic [spo_pkg::RANK_W-1:0]  stored_ranks [ENTRY_CAP];
    int                  stored_count  = 0;
    int                  cfg_my_rank   = spo_pkg::MY_RANK_RST;
    int                  cfg_rank_size = spo_pkg::RANK_SIZE_RST;
    int                  cfg_group     = spo_pkg::GROUP_SIZE_RST;

    t_peer_result        expected_order [$];
    t_peer_result        oldest;
    int                  mismatch_count = 0;
    int                  items_sent     = 0;
    bit                  sender_gaps    = 1'b1;
    bit                  sink_stalls    = 1'b1;

    symmetric_peer_order u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_peer_rank     (i_peer_rank),
        .i_list_end      (i_list_end),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_orig_position (o_orig_position),
        .o_out_rank      (o_out_rank),
        .o_reordered     (o_reordered),
        .o_run_end       (o_run_end),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always #6 i_clk = ~i_clk;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    // Store one accepted item; on list end, queue the emission order
    function automatic void predict_peer_order(input logic [spo_pkg::RANK_W-1:0] rank,
                                               input logic last);
        int     n, remotes, boards, own_board, right_b, left_b, walked, pos, r;
        bit     own_last, reorder;
        int     slot_of [RANK_CAP];
        bit     present [RANK_CAP];
        int     walk [ENTRY_CAP];
        t_peer_result res;
        if (stored_count < ENTRY_CAP) begin
            stored_ranks[stored_count] = rank;
            stored_count++;
        end
        if (!last) return;

        n        = stored_count;
        own_last = n > 0 && stored_ranks[n-1] == cfg_my_rank;
        remotes  = own_last ? n - 1 : n;
        reorder  = 1'b0;
        walked   = 0;
        if (n > 1 && remotes > 1 && cfg_rank_size != 0 && cfg_group != 0 &&
            cfg_rank_size % cfg_group == 0) begin
            // Map each remote rank to its latest position
            for (int i = 0; i < RANK_CAP; i++) present[i] = 1'b0;
            for (int i = 0; i < remotes; i++) begin
                slot_of[stored_ranks[i]] = i;
                present[stored_ranks[i]] = 1'b1;
            end
            boards    = cfg_rank_size / cfg_group;
            own_board = cfg_my_rank / cfg_group;
            // Walk right board ascending, then left board descending
            for (int g = 1; g <= boards / 2; g++) begin
                right_b = (own_board + g) % boards;
                left_b  = (own_board % boards + boards - g) % boards;
                for (int side = 0; side < 2; side++) begin
                    if (side == 1 && left_b == right_b) break;
                    for (int k = 0; k < cfg_group; k++) begin
                        r = (side == 0) ? right_b * cfg_group + k
                                        : left_b * cfg_group + cfg_group - 1 - k;
                        if (r < RANK_CAP && present[r] && walked < ENTRY_CAP) begin
                            walk[walked] = slot_of[r];
                            walked++;
                        end
                    end
                end
            end
            reorder = (walked == remotes);
        end

        for (int i = 0; i < n; i++) begin
            if (!reorder)         pos = i;
            else if (i < remotes) pos = walk[i];
            else                  pos = n - 1;
            res.pos       = pos[spo_pkg::POS_W-1:0];
            res.rank      = stored_ranks[pos];
            res.reordered = reorder;
            res.run_end   = (i == n - 1);
            expected_order.insert(expected_order.size(), res);
        end
        stored_count = 0;
    endfunction

    // Send one item, with a random gap in front when gaps are enabled
    task automatic send_item(input logic [spo_pkg::RANK_W-1:0] rank, input logic last);
        if (sender_gaps && $urandom_range(99) < 22) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < 22);
        end
        i_in_valid  <= 1'b1;
        i_peer_rank <= rank;
        i_list_end  <= last;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predict_peer_order(rank, last);
        items_sent++;
    endtask

    task automatic send_list(input int ranks[$]);
        foreach (ranks[i])
            send_item(ranks[i][spo_pkg::RANK_W-1:0], i == ranks.size() - 1);
    endtask

    // Hold the sender until every predicted result has arrived
    task automatic wait_results_done();
        i_in_valid <= 1'b0;
        while (expected_order.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write one register, then read it back
    task automatic program_reg(input logic [1:0] idx, input int value);
        int want;
        case (idx)
            spo_pkg::REG_MY_RANK:    begin want = value & 'hFF;  cfg_my_rank   = want; end
            spo_pkg::REG_RANK_SIZE:  begin want = value & 'h1FF; cfg_rank_size = want; end
            spo_pkg::REG_GROUP_SIZE: begin want = value & 'h1FF; cfg_group     = want; end
            default:                 want = 0;
        endcase
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= want;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        // Turn the access into a read setup
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (idx == spo_pkg::REG_MY_RANK) begin
            if (prdata[spo_pkg::RANK_W-1:0] !== want[spo_pkg::RANK_W-1:0])
                report_mismatch("my_rank readback", prdata[spo_pkg::RANK_W-1:0], want);
        end else if (prdata[spo_pkg::DIV_W-1:0] !== want[spo_pkg::DIV_W-1:0]) begin
            report_mismatch("size readback", prdata[spo_pkg::DIV_W-1:0], want);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic program_all(input int my_rank, input int rank_size, input int group);
        program_reg(spo_pkg::REG_MY_RANK, my_rank);
        program_reg(spo_pkg::REG_RANK_SIZE, rank_size);
        program_reg(spo_pkg::REG_GROUP_SIZE, group);
    endtask

    // Reset values: eight ranks, one per board, own rank last
    task automatic test_default_order();
        send_list('{3, 1, 7, 5, 2, 6, 4, 0});
        wait_results_done();
    endtask

    task automatic test_single_entry();
        send_list('{5});
        wait_results_done();
    endtask

    // Later duplicate wins, so the walk comes up short
    task automatic test_duplicate_ranks();
        send_list('{2, 1, 2});
        wait_results_done();
    endtask

    // Highest own rank, two boards whose left and right neighbor coincide
    task automatic test_far_own_rank();
        program_all(255, 256, 128);
        send_list('{127, 0, 255});
        wait_results_done();
    endtask

    // Zero sizes and a rank size that does not divide by the group size
    task automatic test_disabled_reorder();
        program_reg(spo_pkg::REG_RANK_SIZE, 0);
        send_list('{1, 2});
        wait_results_done();
        program_all(255, 8, 0);
        send_list('{1, 2});
        wait_results_done();
        program_all(255, 9, 2);
        send_list('{1, 2});
        wait_results_done();
    endtask

    // Entries past the store depth are dropped, the closing flag still counts
    task automatic test_list_overflow();
        int ranks[$];
        program_all(0, 8, 1);
        repeat ($urandom_range(65, 70)) ranks.insert(ranks.size(), $urandom_range(255));
        send_list(ranks);
        wait_results_done();
    endtask

    // Random configurations, each followed by a mix of lists
    task automatic test_random_phases();
        int rs, gs, mr, boards, own, budget, start, mark, kind, len, j, swap, phase;
        int pool[$];
        int ranks[$];
        phase = 0;
        start = items_sent;
        while (items_sent - start < RANDOM_ITEMS) begin
            case ($urandom_range(9))
                0:       begin rs = 256; gs = 1; end
                1:       begin rs = $urandom_range(256); gs = $urandom_range(256); end
                2:       begin rs = 0; gs = $urandom_range(1, 256); end
                3:       begin rs = 256; gs = 256; end
                4:       begin rs = $urandom_range(1, 256); gs = 0; end
                default: begin
                    gs = 1 << $urandom_range(6);
                    rs = gs * $urandom_range(1, 256 / gs);
                end
            endcase
            mr = ($urandom_range(1) && rs > 0) ? $urandom_range(rs - 1) : $urandom_range(255);
            program_all(mr, rs, gs);

            // Ranks that a complete walk can reach
            pool.delete();
            if (rs != 0 && gs != 0 && rs % gs == 0) begin
                boards = rs / gs;
                own    = (mr / gs) % boards;
                for (int r = 0; r < rs; r++) if (r / gs != own) pool.insert(pool.size(), r);
            end

            // Run one phase with no sender gaps and no sink stalls
            sender_gaps = (phase != 2);
            sink_stalls = (phase != 2);
            budget = $urandom_range(40, 70);
            mark   = items_sent;
            while (items_sent - mark < budget) begin
                ranks.delete();
                kind = $urandom_range(99);
                if (kind < 80 && pool.size() >= 2) begin
                    len = $urandom_range(2, ($urandom_range(9) == 0) ? 63 : 10);
                    if (len > pool.size()) len = pool.size();
                    for (int i = 0; i < len; i++) begin
                        j = $urandom_range(i, pool.size() - 1);
                        swap = pool[i]; pool[i] = pool[j]; pool[j] = swap;
                        ranks.insert(ranks.size(), pool[i]);
                    end
                    // Break some lists: a duplicate or a stray rank
                    if (kind >= 65) begin
                        j = $urandom_range(len - 1);
                        ranks[j] = $urandom_range(1) ? ranks[$urandom_range(len - 1)]
                                                     : $urandom_range(255);
                    end
                    if ($urandom_range(9) < 8) ranks.insert(ranks.size(), mr);
                end else begin
                    len = $urandom_range(1, 12);
                    repeat (len) ranks.insert(ranks.size(), $urandom_range(255));
                    if (len > 1 && $urandom_range(2) == 0)
                        ranks[$urandom_range(len - 1)] = ranks[0];
                end
                send_list(ranks);
            end
            wait_results_done();
            phase++;
        end
        sender_gaps = 1'b1;
        sink_stalls = 1'b1;
    endtask

    // Compare each accepted result with the oldest prediction; drive sink stalls
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_order.size() == 0) begin
                report_mismatch("unexpected result, position", o_orig_position, -1);
            end else begin
                oldest = expected_order.pop_front();
                if (o_orig_position !== oldest.pos)
                    report_mismatch("orig_position", o_orig_position, oldest.pos);
                if (o_out_rank !== oldest.rank)
                    report_mismatch("out_rank", o_out_rank, oldest.rank);
                if (o_reordered !== oldest.reordered)
                    report_mismatch("reordered", o_reordered, oldest.reordered);
                if (o_run_end !== oldest.run_end)
                    report_mismatch("run_end", o_run_end, oldest.run_end);
            end
        end
        i_out_ready <= sink_stalls ? ($urandom_range(99) >= 22) : 1'b1;
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_default_order();
        test_single_entry();
        test_duplicate_ranks();
        test_far_own_rank();
        test_disabled_reorder();
        test_list_overflow();
        test_random_phases();

        wait_results_done();
        if (mismatch_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // Stop a hung run
    initial begin
        #40_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
